/* rtl/core/uscd_pkg.sv */
// ----------------------------------------------------------------------------
// uscd_pkg
// Shared types, constants and lookup tables for the seconds-to-date pipeline.
// ----------------------------------------------------------------------------
package uscd_pkg;

   // pipeline depth, one register stage per entry
   localparam int unsigned STAGES = 6;

   localparam logic [11:0] YEAR_BASE    = 12'd1970;
   localparam logic [16:0] SECS_PER_DAY = 17'd86400;
   localparam logic [11:0] SECS_PER_HR  = 12'd3600;
   localparam logic [11:0] SECS_PER_MIN = 12'd60;
   localparam int unsigned YEAR_COUNT   = 137;
   // 2100 is the one century year in range that is not a leap year
   localparam logic [7:0]  NOLEAP_IDX   = 8'd130;
   localparam logic [1:0]  LEAP_PHASE   = 2'd2;

   // reciprocals for division by constants, exact over the input range
   // days = (secs >> 7) / 675
   localparam logic [25:0] RECIP_DAY  = 26'(((64'd1 << 35) + 64'd674) / 64'd675);
   localparam int unsigned SHIFT_DAY  = 35;
   // lower bound of the year index: days / 366
   localparam logic [16:0] RECIP_YEAR = 17'(((64'd1 << 25) + 64'd365) / 64'd366);
   // hour = (sod >> 4) / 225
   localparam logic [13:0] RECIP_HR   = 14'(((64'd1 << 21) + 64'd224) / 64'd225);
   // minute = (rem >> 2) / 15
   localparam logic [10:0] RECIP_MIN  = 11'(((64'd1 << 14) + 64'd14) / 64'd15);

   typedef struct packed {
      logic [STAGES-1:0] load;
      logic [STAGES-1:0] valid;
   } pipe_ctrl_type;

   localparam logic [15:0] JAN_FIRST [0:YEAR_COUNT-1] = '{
      16'd0,     16'd365,   16'd730,   16'd1096,  16'd1461,  16'd1826,  16'd2191,
      16'd2557,  16'd2922,  16'd3287,  16'd3652,  16'd4018,  16'd4383,  16'd4748,
      16'd5113,  16'd5479,  16'd5844,  16'd6209,  16'd6574,  16'd6940,  16'd7305,
      16'd7670,  16'd8035,  16'd8401,  16'd8766,  16'd9131,  16'd9496,  16'd9862,
      16'd10227, 16'd10592, 16'd10957, 16'd11323, 16'd11688, 16'd12053, 16'd12418,
      16'd12784, 16'd13149, 16'd13514, 16'd13879, 16'd14245, 16'd14610, 16'd14975,
      16'd15340, 16'd15706, 16'd16071, 16'd16436, 16'd16801, 16'd17167, 16'd17532,
      16'd17897, 16'd18262, 16'd18628, 16'd18993, 16'd19358, 16'd19723, 16'd20089,
      16'd20454, 16'd20819, 16'd21184, 16'd21550, 16'd21915, 16'd22280, 16'd22645,
      16'd23011, 16'd23376, 16'd23741, 16'd24106, 16'd24472, 16'd24837, 16'd25202,
      16'd25567, 16'd25933, 16'd26298, 16'd26663, 16'd27028, 16'd27394, 16'd27759,
      16'd28124, 16'd28489, 16'd28855, 16'd29220, 16'd29585, 16'd29950, 16'd30316,
      16'd30681, 16'd31046, 16'd31411, 16'd31777, 16'd32142, 16'd32507, 16'd32872,
      16'd33238, 16'd33603, 16'd33968, 16'd34333, 16'd34699, 16'd35064, 16'd35429,
      16'd35794, 16'd36160, 16'd36525, 16'd36890, 16'd37255, 16'd37621, 16'd37986,
      16'd38351, 16'd38716, 16'd39082, 16'd39447, 16'd39812, 16'd40177, 16'd40543,
      16'd40908, 16'd41273, 16'd41638, 16'd42004, 16'd42369, 16'd42734, 16'd43099,
      16'd43465, 16'd43830, 16'd44195, 16'd44560, 16'd44926, 16'd45291, 16'd45656,
      16'd46021, 16'd46387, 16'd46752, 16'd47117, 16'd47482, 16'd47847, 16'd48212,
      16'd48577, 16'd48942, 16'd49308, 16'd49673
   };

   localparam logic [8:0] MONTH_COMMON [0:11] = '{
      9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
      9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
   };

   localparam logic [8:0] MONTH_LEAP [0:11] = '{
      9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
      9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335
   };

   // day number of january 1st; indexes past the table read as all ones
   function automatic logic [15:0] jan_first(input logic [7:0] idx);
      logic [15:0] res;
      if (idx < 8'(YEAR_COUNT)) begin
         res = JAN_FIRST[idx];
      end else begin
         res = '1;
      end
      return res;
   endfunction

   function automatic logic [8:0] month_start(input logic leap, input logic [3:0] idx);
      logic [8:0] res;
      if (idx > 4'd11) begin
         res = '1;
      end else if (leap) begin
         res = MONTH_LEAP[idx];
      end else begin
         res = MONTH_COMMON[idx];
      end
      return res;
   endfunction

endpackage

/* rtl/core/unix_seconds_to_calendar_date_unit.sv */
// ----------------------------------------------------------------------------
// unix_seconds_to_calendar_date_unit
// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 into time of
// day and gregorian date through a six-stage pipeline.
// ----------------------------------------------------------------------------
//  channel   dir   handshake            payload
//  req_      in    req_valid/req_stall  req_unix_seconds[31:0]
//  rsp_      out   rsp_valid/rsp_stall  second, minute, hour, day_of_month,
//                                       month_number, year_number
//
//  a request passes through the six register stages, 0 to 5, and rsp_valid
//  rises when it reaches the output stage; one item can enter every cycle
//  while req_stall is low
//  reset clears only the stage valid bits, payload registers are not reset
//  a stalled result holds in the output stage; earlier stages keep filling
//  until every stage is full, then req_stall rises
// ----------------------------------------------------------------------------
module unix_seconds_to_calendar_date_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_unix_seconds,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [5:0]  rsp_second,
   output logic [5:0]  rsp_minute,
   output logic [4:0]  rsp_hour,
   output logic [4:0]  rsp_day_of_month,
   output logic [3:0]  rsp_month_number,
   output logic [11:0] rsp_year_number
);

   uscd_pkg::pipe_ctrl_type ctrl;

   uscd_pipe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .out_stall (rsp_stall),
      .in_stall  (req_stall),
      .ctrl      (ctrl)
   );

   // stage 0: whole days
   logic [50:0] day_prod;
   logic [15:0] days0_ff;
   logic [16:0] secs0_ff;

   assign day_prod = 51'(req_unix_seconds[31:7]) * 51'(uscd_pkg::RECIP_DAY);

   always_ff @(posedge clock) begin
      if (ctrl.load[0]) begin
         days0_ff <= day_prod[uscd_pkg::SHIFT_DAY +: 16];
         secs0_ff <= req_unix_seconds[16:0];
      end
   end

   // stage 1: second of day and year index estimate
   logic [32:0] dsec_prod;
   logic [32:0] year_prod;
   logic [15:0] days1_ff;
   logic [16:0] sod1_ff;
   logic [7:0]  est1_ff;

   assign dsec_prod = 33'(days0_ff) * 33'(uscd_pkg::SECS_PER_DAY);
   assign year_prod = 33'(days0_ff) * 33'(uscd_pkg::RECIP_YEAR);

   always_ff @(posedge clock) begin
      if (ctrl.load[1]) begin
         days1_ff <= days0_ff;
         sod1_ff  <= secs0_ff - dsec_prod[16:0];
         est1_ff  <= year_prod[32:25];
      end
   end

   // stage 2: year index and day of year, hour
   // the estimate is the true index or one below it
   logic [15:0] jan_lo;
   logic [15:0] jan_hi;
   logic [16:0] diff_lo;
   logic [16:0] diff_hi;
   logic [26:0] hr_prod;
   logic [7:0]  yi2_in;
   logic [8:0]  doy2_in;
   logic [7:0]  yi2_ff;
   logic [8:0]  doy2_ff;
   logic [16:0] sod2_ff;
   logic [4:0]  hour2_ff;

   assign jan_lo  = uscd_pkg::jan_first(est1_ff);
   assign jan_hi  = uscd_pkg::jan_first(est1_ff + 8'd1);
   assign diff_lo = {1'b0, days1_ff} - {1'b0, jan_lo};
   assign diff_hi = {1'b0, days1_ff} - {1'b0, jan_hi};
   assign hr_prod = 27'(sod1_ff[16:4]) * 27'(uscd_pkg::RECIP_HR);

   always_comb begin
      if (!diff_hi[16]) begin
         yi2_in  = est1_ff + 8'd1;
         doy2_in = diff_hi[8:0];
      end else begin
         yi2_in  = est1_ff;
         doy2_in = diff_lo[8:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[2]) begin
         yi2_ff   <= yi2_in;
         doy2_ff  <= doy2_in;
         sod2_ff  <= sod1_ff;
         hour2_ff <= hr_prod[25:21];
      end
   end

   // stage 3: leap flag, month index, seconds within the hour
   logic        leap3_in;
   logic [3:0]  mi3_in;
   logic [16:0] hsec_prod;
   logic [11:0] year3_ff;
   logic        leap3_ff;
   logic [3:0]  mi3_ff;
   logic [8:0]  doy3_ff;
   logic [11:0] rem3_ff;
   logic [4:0]  hour3_ff;

   // year 1970 + index is a multiple of four when index mod 4 is 2
   assign leap3_in  = (yi2_ff[1:0] == uscd_pkg::LEAP_PHASE) && (yi2_ff != uscd_pkg::NOLEAP_IDX);
   assign hsec_prod = 17'(hour2_ff) * 17'(uscd_pkg::SECS_PER_HR);

   always_comb begin
      mi3_in = 4'd0;
      for (int k = 1; k < 12; k++) begin
         if (uscd_pkg::month_start(leap3_in, 4'(k)) <= doy2_ff) begin
            mi3_in = mi3_in + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[3]) begin
         year3_ff <= uscd_pkg::YEAR_BASE + 12'(yi2_ff);
         leap3_ff <= leap3_in;
         mi3_ff   <= mi3_in;
         doy3_ff  <= doy2_ff;
         rem3_ff  <= 12'(sod2_ff - hsec_prod);
         hour3_ff <= hour2_ff;
      end
   end

   // stage 4: day of month, minute
   logic [8:0]  mstart;
   logic [8:0]  dom_full;
   logic [20:0] min_prod;
   logic [11:0] year4_ff;
   logic [3:0]  month4_ff;
   logic [4:0]  dom4_ff;
   logic [11:0] rem4_ff;
   logic [4:0]  hour4_ff;
   logic [5:0]  min4_ff;

   assign mstart   = uscd_pkg::month_start(leap3_ff, mi3_ff);
   assign dom_full = doy3_ff - mstart + 9'd1;
   assign min_prod = 21'(rem3_ff[11:2]) * 21'(uscd_pkg::RECIP_MIN);

   always_ff @(posedge clock) begin
      if (ctrl.load[4]) begin
         year4_ff  <= year3_ff;
         month4_ff <= mi3_ff + 4'd1;
         dom4_ff   <= dom_full[4:0];
         rem4_ff   <= rem3_ff;
         hour4_ff  <= hour3_ff;
         min4_ff   <= min_prod[19:14];
      end
   end

   // stage 5: second, output register
   logic [11:0] msec_prod;
   logic [11:0] sec_full;
   logic [5:0]  sec5_ff;
   logic [5:0]  min5_ff;
   logic [4:0]  hour5_ff;
   logic [4:0]  dom5_ff;
   logic [3:0]  month5_ff;
   logic [11:0] year5_ff;

   assign msec_prod = 12'(min4_ff) * uscd_pkg::SECS_PER_MIN;
   assign sec_full  = rem4_ff - msec_prod;

   always_ff @(posedge clock) begin
      if (ctrl.load[5]) begin
         sec5_ff   <= sec_full[5:0];
         min5_ff   <= min4_ff;
         hour5_ff  <= hour4_ff;
         dom5_ff   <= dom4_ff;
         month5_ff <= month4_ff;
         year5_ff  <= year4_ff;
      end
   end

   assign rsp_valid        = ctrl.valid[uscd_pkg::STAGES-1];
   assign rsp_second       = sec5_ff;
   assign rsp_minute       = min5_ff;
   assign rsp_hour         = hour5_ff;
   assign rsp_day_of_month = dom5_ff;
   assign rsp_month_number = month5_ff;
   assign rsp_year_number  = year5_ff;

   // time of day fields stay in range
   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_second < 6'd60) && (rsp_minute < 6'd60) && (rsp_hour < 5'd24))
      else $error("time of day out of range");

   // date fields stay in range
   a_date_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_month_number >= 4'd1) && (rsp_month_number <= 4'd12)
                    && (rsp_day_of_month != 5'd0) && (rsp_year_number >= 12'd1970)
                    && (rsp_year_number <= 12'd2106))
      else $error("date out of range");

   // the input is held off only when every stage is occupied
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&ctrl.valid) && rsp_stall)
      else $error("input stalled with room in the pipeline");

endmodule

/* rtl/core/uscd_pipe_ctrl.sv */
// ----------------------------------------------------------------------------
// uscd_pipe_ctrl
// Valid bits and per-stage load enables; a stage takes new data when it is
// empty or its contents move on, so bubbles close up behind a stall.
// ----------------------------------------------------------------------------
module uscd_pipe_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic                   out_stall,
   output logic                   in_stall,
   output uscd_pkg::pipe_ctrl_type ctrl
);

   logic [uscd_pkg::STAGES-1:0] valid_ff;
   logic [uscd_pkg::STAGES-1:0] valid_in;
   logic [uscd_pkg::STAGES-1:0] ready;

   always_comb begin
      ready[uscd_pkg::STAGES-1] = !valid_ff[uscd_pkg::STAGES-1] || !out_stall;
      for (int i = int'(uscd_pkg::STAGES) - 2; i >= 0; i--) begin
         ready[i] = !valid_ff[i] || ready[i+1];
      end
   end

   always_comb begin
      for (int i = 0; i < int'(uscd_pkg::STAGES); i++) begin
         if (!ready[i]) begin
            valid_in[i] = valid_ff[i];
         end else if (i == 0) begin
            valid_in[i] = in_valid;
         end else begin
            valid_in[i] = valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign in_stall   = !ready[0];
   assign ctrl.load  = ready;
   assign ctrl.valid = valid_ff;

endmodule

/* dv/tb_unix_seconds_to_calendar_date_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_unix_seconds_to_calendar_date_unit
// Drives seconds counts into the date converter and checks every returned
// time of day and calendar date against a predictor built from plain
// year and month stepping. Covers edge and leap-year cases, random counts,
// random idling on both channels and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_unix_seconds_to_calendar_date_unit;

   typedef struct packed {
      logic [5:0]  second;
      logic [5:0]  minute;
      logic [4:0]  hour;
      logic [4:0]  day_of_month;
      logic [3:0]  month_number;
      logic [11:0] year_number;
   } cal_date_type;

   class date_scoreboard;
      cal_date_type pending_dates[$];
      int           error_count = 0;

      // walks forward year by year, then month by month
      function cal_date_type seconds_to_date(input logic [31:0] secs);
         cal_date_type res;
         int unsigned  days, tod, yr, year_start, year_len, doy, mon, mon_len;
         bit           leap;
         days = secs / 86400;
         tod  = secs % 86400;
         res.hour   = 5'(tod / 3600);
         res.minute = 6'((tod % 3600) / 60);
         res.second = 6'(tod % 60);
         yr = 1970;
         year_start = 0;
         forever begin
            leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
            year_len = leap ? 366 : 365;
            if (days < year_start + year_len) break;
            year_start += year_len;
            yr++;
         end
         doy = days - year_start;
         mon = 1;
         forever begin
            case (mon)
               2:             mon_len = leap ? 29 : 28;
               4, 6, 9, 11:   mon_len = 30;
               default:       mon_len = 31;
            endcase
            if (doy < mon_len) break;
            doy -= mon_len;
            mon++;
         end
         res.day_of_month = 5'(doy + 1);
         res.month_number = 4'(mon);
         res.year_number  = 12'(yr);
         return res;
      endfunction

      function void note_seconds(input logic [31:0] secs);
         pending_dates.push_back(seconds_to_date(secs));
      endfunction

      function void check_date(input cal_date_type got);
         cal_date_type want;
         if (pending_dates.size() == 0) begin
            $error("result transfer with no expected date pending");
            error_count++;
            return;
         end
         want = pending_dates.pop_front();
         if (got.second !== want.second) begin
            $error("second: expected %0d, actual %0d", want.second, got.second);
            error_count++;
         end
         if (got.minute !== want.minute) begin
            $error("minute: expected %0d, actual %0d", want.minute, got.minute);
            error_count++;
         end
         if (got.hour !== want.hour) begin
            $error("hour: expected %0d, actual %0d", want.hour, got.hour);
            error_count++;
         end
         if (got.day_of_month !== want.day_of_month) begin
            $error("day_of_month: expected %0d, actual %0d",
                   want.day_of_month, got.day_of_month);
            error_count++;
         end
         if (got.month_number !== want.month_number) begin
            $error("month_number: expected %0d, actual %0d",
                   want.month_number, got.month_number);
            error_count++;
         end
         if (got.year_number !== want.year_number) begin
            $error("year_number: expected %0d, actual %0d",
                   want.year_number, got.year_number);
            error_count++;
         end
      endfunction

      function int pending();
         return pending_dates.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_unix_seconds = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [5:0]  rsp_second;
   logic [5:0]  rsp_minute;
   logic [4:0]  rsp_hour;
   logic [4:0]  rsp_day_of_month;
   logic [3:0]  rsp_month_number;
   logic [11:0] rsp_year_number;

   date_scoreboard board;
   bit             no_idle;
   bit             sender_busy;
   bit             hold_off_req;

   unix_seconds_to_calendar_date_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_unix_seconds (req_unix_seconds),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_second       (rsp_second),
      .rsp_minute       (rsp_minute),
      .rsp_hour         (rsp_hour),
      .rsp_day_of_month (rsp_day_of_month),
      .rsp_month_number (rsp_month_number),
      .rsp_year_number  (rsp_year_number)
   );

   always #5 clock = ~clock;

   // mostly short, now and then long
   function automatic int idle_length();
      if ($urandom_range(0, 99) < 80) begin
         return $urandom_range(1, 3);
      end else begin
         return $urandom_range(8, 30);
      end
   endfunction

   task automatic send_seconds(input logic [31:0] secs);
      int gap;
      gap = (no_idle || sender_busy || $urandom_range(0, 99) < 55) ? 0 : idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_unix_seconds <= secs;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_seconds(secs);
   endtask

   task automatic wait_all_results();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   // result side: random stall bursts, long hold-off on request
   initial begin
      int  burst_left;
      int  hold_left;
      bit  burst_stall;
      burst_left  = 0;
      hold_left   = 0;
      burst_stall = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) begin
            board.check_date({rsp_second, rsp_minute, rsp_hour, rsp_day_of_month,
                              rsp_month_number, rsp_year_number});
         end
         if (hold_off_req) begin
            hold_left    = 200;
            hold_off_req = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (no_idle) begin
            rsp_stall <= 1'b0;
         end else begin
            if (burst_left == 0) begin
               burst_stall = ($urandom_range(0, 99) < 40);
               burst_left  = burst_stall ? idle_length() : $urandom_range(1, 16);
            end
            burst_left--;
            rsp_stall <= burst_stall;
         end
      end
   end

   initial begin
      logic [31:0]     directed_secs[$];
      logic [31:0]     secs;
      longint unsigned stamp;
      int              sel;
      board = new();
      directed_secs = '{
         32'd0, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
         32'd5097600,      // first of march in a common year
         32'd31535999,     // last second of the first year
         32'd68169600,     // leap day of the first leap year
         32'd94694399,     // end of a leap year
         32'd951782400,    // leap day of a 400-year century
         32'd978307199,    // end of that century year
         32'd4107542399,   // last second of february in a non-leap century
         32'd4107542400,   // followed directly by march first
         32'd4291747199,   // end of the second to last year
         32'd4291747200,   // start of the last year
         32'h7FFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555,
         32'hFFFF_FFFE, 32'hFFFF_FFFF
      };
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_secs[i]) send_seconds(directed_secs[i]);
      wait_all_results();

      for (int n = 0; n < 1080; n++) begin
         // pressure: receiver holds off while the sender keeps offering
         if (n == 300) begin
            hold_off_req = 1'b1;
            sender_busy  = 1'b1;
         end
         if (n == 360) sender_busy = 1'b0;
         if (n == 500) no_idle = 1'b1;
         if (n == 600) no_idle = 1'b0;
         if (n == 800) begin
            wait_all_results();
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
         sel = $urandom_range(0, 99);
         if (sel < 50) begin
            secs = $urandom;
         end else if (sel < 75) begin
            // land on or next to a midnight, or anywhere within a random day
            stamp = longint'($urandom_range(0, 49710)) * 86400;
            case ($urandom_range(0, 2))
               0:       stamp = stamp;
               1:       stamp = stamp + 86399;
               default: stamp = stamp + $urandom_range(0, 86399);
            endcase
            secs = (stamp > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF - $urandom_range(0, 1000)
                                           : 32'(stamp);
         end else if (sel < 90) begin
            secs = 32'hFFFF_FFFF - $urandom_range(0, 40_000_000);
         end else begin
            secs = $urandom_range(0, 100_000_000);
         end
         send_seconds(secs);
      end
      wait_all_results();
      repeat (20) @(posedge clock);

      if (board.pending() != 0) begin
         $error("%0d expected dates never arrived", board.pending());
      end
      if (board.error_count == 0 && board.pending() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
